/* hw/rtl/u8lc_pkg.sv */
// Shared types, constants and helper functions for the UTF-8 Latin-1 case mapper.
// Depends on nothing; every other file of the block but u8lc_if.sv imports it.
`default_nettype none

package u8lc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CpW-1:0] ReplCp   = 21'h00FFFD;
  localparam logic [1:0]     ContTag  = 2'b10;
  localparam logic           ModeUpper = 1'b0;

  // One decoded work item: a run of replacement characters, then an optional code point.
  typedef struct packed {
    logic [1:0]     n_repl;
    logic           has_cp;
    logic [CpW-1:0] cp;
    logic           last;
  } q_entry_t;

  // Number of continuation bytes a lead byte calls for; zero for ASCII or a bad lead.
  function automatic logic [1:0] conts_needed(input logic [ByteW-1:0] lead);
    logic [1:0] n;
    priority if (lead[7:5] == 3'b110) begin
      n = 2'd1;
    end else if (lead[7:4] == 4'b1110) begin
      n = 2'd2;
    end else if (lead[7:3] == 5'b11110) begin
      n = 2'd3;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

  function automatic logic [CpW-1:0] map_case(input logic [CpW-1:0] cp, input logic mode);
    logic [CpW-1:0] res;
    res = cp;
    if (mode == ModeUpper) begin
      if ((cp >= 21'h61 && cp <= 21'h7A) ||
          (cp >= 21'hE0 && cp <= 21'hFE && cp != 21'hF7)) begin
        res = cp - 21'h20;
      end else if (cp == 21'hFF) begin
        res = 21'h178;
      end
    end else begin
      if ((cp >= 21'h41 && cp <= 21'h5A) ||
          (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7)) begin
        res = cp + 21'h20;
      end else if (cp == 21'h178) begin
        res = 21'hFF;
      end
    end
    return res;
  endfunction

  // Encoded length of a code point, minus one.
  function automatic logic [1:0] enc_len_m1(input logic [CpW-1:0] cp);
    logic [1:0] n;
    priority if (cp < 21'h80) begin
      n = 2'd0;
    end else if (cp < 21'h800) begin
      n = 2'd1;
    end else if (cp < 21'h10000) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [ByteW-1:0] enc_byte(input logic [CpW-1:0] cp,
                                                input logic [1:0] len_m1,
                                                input logic [1:0] idx);
    logic [ByteW-1:0] b;
    b = {ContTag, cp[5:0]};
    unique case (len_m1)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: begin
        if (idx == 2'd0) b = {3'b110, cp[10:6]};
      end
      2'd2: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {ContTag, cp[11:6]};
          default: b = {ContTag, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {ContTag, cp[17:12]};
          2'd2:    b = {ContTag, cp[11:6]};
          default: b = {ContTag, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/u8lc_if.sv */
// Valid/ready stream interfaces for the input bytes and the mapped output bytes.
// Depends on nothing.
`default_nettype none

interface u8lc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface u8lc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;
  modport source(output valid, output out_byte, output run_end, output string_end,
                 input ready);
  modport sink(input valid, input out_byte, input run_end, input string_end,
               output ready);
endinterface

`default_nettype wire

/* hw/rtl/u8lc_front.sv */
// Front end: accepts bytes, holds partial sequences, decodes and case-maps code points.
// Depends on u8lc_pkg and u8lc_if; pushes one work item per productive byte.
`default_nettype none

module u8lc_front
  import u8lc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  u8lc_in_if.sink       in_ch,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_data
);

  logic             case_mode_r;
  logic [1:0]       pend_cnt_r, pend_cnt_nxt;
  logic [ByteW-1:0] pend_r [3];

  logic             acc;
  logic [ByteW-1:0] b;
  logic             is_cont;
  logic [1:0]       need;
  logic [CpW-1:0]   dec_cp;
  logic [CpW-1:0]   raw_cp;
  logic [1:0]       n_repl;
  logic             has_cp;
  logic             store_lead;
  logic             store_cont;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign is_cont     = (b[7:6] == ContTag);
  assign need        = conts_needed(pend_r[0]);

  always_comb begin
    unique case (need)
      2'd1:    dec_cp = {10'd0, pend_r[0][4:0], b[5:0]};
      2'd2:    dec_cp = {5'd0, pend_r[0][3:0], pend_r[1][5:0], b[5:0]};
      default: dec_cp = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], b[5:0]};
    endcase
  end

  always_comb begin
    pend_cnt_nxt = pend_cnt_r;
    n_repl       = 2'd0;
    has_cp       = 1'b0;
    raw_cp       = ReplCp;
    store_lead   = 1'b0;
    store_cont   = 1'b0;
    if (pend_cnt_r != 2'd0 && is_cont) begin
      if (pend_cnt_r >= need) begin
        has_cp       = 1'b1;
        raw_cp       = dec_cp;
        pend_cnt_nxt = 2'd0;
      end else begin
        store_cont = 1'b1;
        if (in_ch.in_last) begin
          // The held lead, the held continuations and this one each become a replacement.
          n_repl       = pend_cnt_r + 2'd1;
          pend_cnt_nxt = 2'd0;
        end else begin
          pend_cnt_nxt = pend_cnt_r + 2'd1;
        end
      end
    end else begin
      n_repl       = pend_cnt_r;
      pend_cnt_nxt = 2'd0;
      if (!b[7]) begin
        has_cp = 1'b1;
        raw_cp = {13'd0, b};
      end else if (conts_needed(b) == 2'd0 || in_ch.in_last) begin
        has_cp = 1'b1;
        raw_cp = ReplCp;
      end else begin
        store_lead   = 1'b1;
        pend_cnt_nxt = 2'd1;
      end
    end
  end

  assign q_push        = acc && (has_cp || n_repl != 2'd0);
  assign q_data.n_repl = n_repl;
  assign q_data.has_cp = has_cp;
  assign q_data.cp     = map_case(raw_cp, case_mode_r);
  assign q_data.last   = in_ch.in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_mode_r <= ModeUpper;
      pend_cnt_r  <= 2'd0;
    end else begin
      if (cfg_wr_en) case_mode_r <= cfg_wr_data;
      if (acc) pend_cnt_r <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && store_lead) pend_r[0] <= b;
    if (acc && store_cont) pend_r[pend_cnt_r] <= b;
  end

endmodule

`default_nettype wire

/* hw/rtl/u8lc_fifo.sv */
// Short work queue between the decoding front end and the encoding back end.
// Depends on u8lc_pkg for the entry type and depth.
`default_nettype none

module u8lc_fifo
  import u8lc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output q_entry_t      head
);

  q_entry_t          mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r;
  logic [QPtrW-1:0]  rd_ptr_r;
  logic [QCntW-1:0]  cnt_r;

  assign full      = (cnt_r == QCntW'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

/* hw/rtl/u8lc_back.sv */
// Back end: expands each queued work item into UTF-8 bytes behind an output register.
// Depends on u8lc_pkg and u8lc_if.
`default_nettype none

module u8lc_back
  import u8lc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_not_empty,
  input  wire q_entry_t q_head,
  output logic          q_pop,
  u8lc_out_if.source    out_ch
);

  logic [1:0]       unit_r;
  logic [1:0]       byte_r;
  logic             out_valid_r;
  logic [ByteW-1:0] out_byte_r;
  logic             run_end_r;
  logic             string_end_r;

  logic             advance;
  logic [2:0]       units;
  logic [1:0]       units_m1;
  logic             cur_repl;
  logic [CpW-1:0]   cur_cp;
  logic [1:0]       len_m1;
  logic             last_byte;
  logic             last_unit;

  // Replacement characters come first, then the item's own code point.
  assign units     = {1'b0, q_head.n_repl} + {2'b00, q_head.has_cp} - 3'd1;
  assign units_m1  = units[1:0];
  assign cur_repl  = (unit_r < q_head.n_repl);
  assign cur_cp    = cur_repl ? ReplCp : q_head.cp;
  assign len_m1    = enc_len_m1(cur_cp);
  assign last_byte = (byte_r == len_m1);
  assign last_unit = (unit_r == units_m1);
  assign advance   = q_not_empty && (!out_valid_r || out_ch.ready);
  assign q_pop     = advance && last_byte && last_unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r      <= 2'd0;
      byte_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        if (last_byte) begin
          byte_r <= 2'd0;
          unit_r <= last_unit ? 2'd0 : unit_r + 2'd1;
        end else begin
          byte_r <= byte_r + 2'd1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= enc_byte(cur_cp, len_m1, byte_r);
      run_end_r    <= last_byte && last_unit;
      string_end_r <= last_byte && last_unit && q_head.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_end    = run_end_r;
  assign out_ch.string_end = string_end_r;

endmodule

`default_nettype wire

/* hw/rtl/utf8_latin1_case_mapper.sv */
// The first output byte of an input byte passes through the work queue and then the
// output register before it can transfer.
// Throughput: one input byte per cycle, and one output byte per cycle while the receiver
// is ready; input stalls only while the four-entry work queue is full, which happens when
// items expand to many bytes or the receiver holds off. Each input byte yields zero to
// twelve output bytes. Reset (synchronous, active low) drops any held partial sequence,
// empties the queue and the output register, and sets the mode to upper case.
`default_nettype none

module utf8_latin1_case_mapper
  import u8lc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8lc_in_if.sink    in_ch,
  u8lc_out_if.source out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_not_empty;
  q_entry_t q_in;
  q_entry_t q_head;

  u8lc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  u8lc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  u8lc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

/* tb/sv/utf8_latin1_case_mapper_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for utf8_latin1_case_mapper: streams UTF-8 strings in both
// case modes and compares every mapped output byte with its own model.
// Depends on u8lc_pkg, u8lc_if.sv and the RTL.

module utf8_latin1_case_mapper_test;
  import u8lc_pkg::*;

  localparam logic        ModeLower    = ~ModeUpper;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned DrainLimit   = 20000;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } mapped_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  u8lc_in_if  in_ch();
  u8lc_out_if out_ch();

  utf8_latin1_case_mapper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Model state: the partial sequence held so far and the current case mode.
  logic [7:0]  held_seq [3];
  int unsigned held_n;
  logic        mode_now;

  logic [7:0]  step_bytes [$];
  mapped_t     mapped_q [$];

  int unsigned bytes_in;
  int unsigned bytes_out;
  int unsigned mismatch_count;
  int unsigned hold_seq;
  int unsigned hold_ack;
  logic        steady;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Number of continuation bytes a lead byte asks for; zero for ASCII and bad leads.
  function automatic int unsigned tail_len(input logic [7:0] lead);
    if (lead[7:5] == 3'b110) return 1;
    if (lead[7:4] == 4'b1110) return 2;
    if (lead[7:3] == 5'b11110) return 3;
    return 0;
  endfunction

  function automatic logic [20:0] fold_case(input logic [20:0] cp, input logic m);
    if (m == ModeUpper) begin
      if ((cp >= 21'h61 && cp <= 21'h7A) ||
          (cp >= 21'hE0 && cp <= 21'hFE && cp != 21'hF7)) return cp - 21'h20;
      if (cp == 21'hFF) return 21'h178;
    end else begin
      if ((cp >= 21'h41 && cp <= 21'h5A) ||
          (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7)) return cp + 21'h20;
      if (cp == 21'h178) return 21'hFF;
    end
    return cp;
  endfunction

  // Shortest UTF-8 form of a code point; byte k sits in bits 8k+7..8k.
  function automatic logic [31:0] utf8_pack(input logic [20:0] cp, output int unsigned len);
    logic [31:0] seq;
    seq = '0;
    if (cp < 21'h80) begin
      seq[7:0] = cp[7:0];
      len = 1;
    end else if (cp < 21'h800) begin
      seq[7:0]  = {3'b110, cp[10:6]};
      seq[15:8] = {2'b10, cp[5:0]};
      len = 2;
    end else if (cp < 21'h10000) begin
      seq[7:0]   = {4'b1110, cp[15:12]};
      seq[15:8]  = {2'b10, cp[11:6]};
      seq[23:16] = {2'b10, cp[5:0]};
      len = 3;
    end else begin
      seq[7:0]   = {5'b11110, cp[20:18]};
      seq[15:8]  = {2'b10, cp[17:12]};
      seq[23:16] = {2'b10, cp[11:6]};
      seq[31:24] = {2'b10, cp[5:0]};
      len = 4;
    end
    return seq;
  endfunction

  task automatic emit_cp(input logic [20:0] raw);
    logic [31:0] seq;
    int unsigned len;
    seq = utf8_pack(fold_case(raw, mode_now), len);
    for (int k = 0; k < len; k++) step_bytes = {step_bytes, seq[8*k +: 8]};
  endtask

  // Each held byte of an unfinished sequence turns into one replacement character.
  task automatic flush_held();
    for (int k = 0; k < held_n; k++) emit_cp(ReplCp);
    held_n = 0;
  endtask

  task automatic map_input_byte(input logic [7:0] b, input logic last);
    logic        fresh;
    int unsigned need;
    logic [20:0] cp;
    mapped_t     m;
    step_bytes.delete();
    fresh = 1'b1;
    if (held_n != 0) begin
      if (b[7:6] == 2'b10) begin
        fresh = 1'b0;
        need = tail_len(held_seq[0]);
        if (held_n >= need) begin
          case (need)
            1: cp = 21'({held_seq[0][4:0], b[5:0]});
            2: cp = 21'({held_seq[0][3:0], held_seq[1][5:0], b[5:0]});
            default: cp = {held_seq[0][2:0], held_seq[1][5:0], held_seq[2][5:0], b[5:0]};
          endcase
          held_n = 0;
          emit_cp(cp);
        end else begin
          held_seq[held_n] = b;
          held_n++;
          if (last) flush_held();
        end
      end else begin
        flush_held();
      end
    end
    if (fresh) begin
      if (b < 8'h80) begin
        emit_cp({13'd0, b});
      end else if (tail_len(b) == 0 || last) begin
        emit_cp(ReplCp);
      end else begin
        held_seq[0] = b;
        held_n = 1;
      end
    end
    foreach (step_bytes[k]) begin
      m.data    = step_bytes[k];
      m.run_end = (k == step_bytes.size() - 1);
      m.str_end = m.run_end && last;
      mapped_q = {mapped_q, m};
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    map_input_byte(b, last);
    bytes_in++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    // A byte that only gets held produces nothing, so give the pipeline time to settle.
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_case_mode(input logic m);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_now = m;
  endtask

  function automatic logic [20:0] random_code_point();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 21'($urandom_range(0, 'h7F));
    if (r < 60) return 21'($urandom_range('h80, 'hFF));
    if (r < 65) return 21'h178;
    if (r < 72) return 21'($urandom_range('h100, 'h7FF));
    if (r < 86) return 21'($urandom_range('h800, 'hFFFF));
    return 21'($urandom_range('h10000, 'h1FFFFF));
  endfunction

  // Mostly well-formed characters; some are cut short, some are overlong or plain noise.
  task automatic send_random_string(input int unsigned max_chars);
    logic [7:0]  str [$];
    logic [31:0] seq;
    logic [7:0]  c;
    int unsigned len, keep, n, r;
    n = $urandom_range(1, max_chars);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        seq = utf8_pack(random_code_point(), len);
        keep = (r >= 62 && len > 1) ? $urandom_range(1, len - 1) : len;
        for (int k = 0; k < keep; k++) str = {str, seq[8*k +: 8]};
      end else if (r < 85) begin
        c = 8'($urandom_range(0, 'h7F));
        str = {str, {7'b1100000, c[6]}};
        str = {str, {2'b10, c[5:0]}};
      end else begin
        str = {str, 8'($urandom_range(0, 255))};
      end
    end
    foreach (str[k]) send_byte(str[k], k == str.size() - 1);
  endtask

  task automatic test_directed_upper();
    set_case_mode(ModeUpper);
    // ASCII extremes and letter boundaries.
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h61, 1'b0); send_byte(8'h7A, 1'b1);
    // Latin-1 small letter, y with diaeresis, and the division sign left alone.
    send_byte(8'hC3, 1'b0); send_byte(8'hA0, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hB7, 1'b1);
    // Lone continuation byte and a byte that can never start a sequence.
    send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b1);
    // Three-byte sequence broken by an ASCII byte.
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b1);
    // Full four-byte lead with two continuations, then a bad byte: the widest expansion.
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'hF8, 1'b1);
    // Out-of-range code point is passed through in its four-byte form.
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // A lead byte on the last position, and a sequence cut off by the end of the string.
    send_byte(8'hC3, 1'b1);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
  endtask

  task automatic test_directed_lower();
    set_case_mode(ModeLower);
    send_byte(8'h41, 1'b0); send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'h97, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'h9E, 1'b0);
    send_byte(8'hC5, 1'b0); send_byte(8'hB8, 1'b1);
  endtask

  task automatic test_random_phase(input logic m, input int unsigned count);
    int unsigned stop_at;
    set_case_mode(m);
    stop_at = bytes_in + count;
    while (bytes_in < stop_at) send_random_string(12);
  endtask

  task automatic test_full_rate(input int unsigned count);
    int unsigned stop_at;
    steady = 1'b1;
    stop_at = bytes_in + count;
    while (bytes_in < stop_at) send_random_string(8);
    steady = 1'b0;
  endtask

  // The receiver stops for a long stretch while the sender keeps offering bytes.
  task automatic test_output_stall(input int unsigned count);
    int unsigned stop_at;
    set_case_mode(ModeLower);
    steady = 1'b1;
    hold_seq++;
    // Start sending only once the receiver has actually begun to hold off.
    while (hold_ack != hold_seq) @(posedge clk);
    stop_at = bytes_in + count;
    while (bytes_in < stop_at) send_random_string(10);
    steady = 1'b0;
  endtask

  initial begin : output_pacing
    int unsigned hold_seen, burst, gap;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_ack  = hold_seen;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (steady) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        out_ch.ready <= 1'b1;
        repeat (burst) @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_out
    mapped_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_out++;
      if (mapped_q.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, got %02h", $time,
                 out_ch.out_byte);
        mismatch_count++;
      end else begin
        want = mapped_q.pop_front();
        check_field("out_byte", want.data, out_ch.out_byte);
        check_field("run_end", {7'd0, want.run_end}, {7'd0, out_ch.run_end});
        check_field("string_end", {7'd0, want.str_end}, {7'd0, out_ch.string_end});
      end
    end
  end

  initial begin
    int unsigned waited;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    in_ch.in_last  = 1'b0;
    held_n         = 0;
    mode_now       = ModeUpper;
    bytes_in       = 0;
    bytes_out      = 0;
    mismatch_count = 0;
    hold_seq       = 0;
    hold_ack       = 0;
    steady         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_upper();
    test_directed_lower();
    test_random_phase(ModeLower, 50);
    test_random_phase(ModeUpper, 50);
    test_full_rate(45);
    test_output_stall(55);
    test_random_phase(ModeUpper, 45);
    test_random_phase(ModeLower, 45);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (mapped_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (mapped_q.size() != 0) begin
      $display("%0t: %0d output bytes never arrived, next expected %02h", $time,
               mapped_q.size(), mapped_q[0].data);
      mismatch_count++;
    end

    $display("Sent %0d input bytes and checked %0d mapped bytes in upper and lower case mode,",
             bytes_in, bytes_out);
    $display("including broken, overlong and out-of-range sequences and a long output stall.");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
